### hdl/obwg_pkg.sv
// ----------------------------------------------------------------------------
// obwg_pkg
// Shared types, constants and tables of the oriented box wireframe generator.
// ----------------------------------------------------------------------------
package obwg_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int BOX_VERTS        = 24;
  localparam int CAP_W            = 13;
  localparam int CAP_RESET        = 4096;
  localparam int LEN_SQ_EPS       = 2684;     // 0.00001 in units of 2^-28
  localparam int QUEUE_DEPTH      = 2;
  localparam int IN_DATA_W        = 264;
  localparam int OUT_DATA_W       = 112;
  localparam int APB_ADDR_W       = 3;

  // register word index
  localparam logic REG_CAPACITY = 1'b0;

  // color codes
  localparam logic [3:0] COL_HIT       = 4'd0;
  localparam logic [3:0] COL_PL_ATTACK = 4'd1;
  localparam logic [3:0] COL_COUNTER   = 4'd2;
  localparam logic [3:0] COL_EN_ATTACK = 4'd3;
  localparam logic [3:0] COL_EN_PROJ   = 4'd4;
  localparam logic [3:0] COL_REFLECTED = 4'd5;
  localparam logic [3:0] COL_PLAYER    = 4'd6;
  localparam logic [3:0] COL_ENEMY     = 4'd7;
  localparam logic [3:0] COL_OTHER     = 4'd8;

  // class bit positions
  localparam int CLS_PLAYER    = 0;
  localparam int CLS_ENEMY     = 1;
  localparam int CLS_PL_ATTACK = 2;
  localparam int CLS_EN_ATTACK = 3;
  localparam int CLS_COUNTER   = 4;
  localparam int CLS_EN_PROJ   = 5;
  localparam int CLS_REFLECTED = 6;
  localparam int CLS_HIT       = 7;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [30:0]        sz;
    logic [3:0]         color;
    logic [11:0]        base;
  } box_t;

  function automatic logic [3:0] pick_color(input logic [7:0] cls);
    logic [3:0] c;
    if (cls[CLS_HIT])            c = COL_HIT;
    else if (cls[CLS_PL_ATTACK]) c = COL_PL_ATTACK;
    else if (cls[CLS_COUNTER])   c = COL_COUNTER;
    else if (cls[CLS_EN_ATTACK]) c = COL_EN_ATTACK;
    else if (cls[CLS_EN_PROJ])   c = COL_EN_PROJ;
    else if (cls[CLS_REFLECTED]) c = COL_REFLECTED;
    else if (cls[CLS_PLAYER])    c = COL_PLAYER;
    else if (cls[CLS_ENEMY])     c = COL_ENEMY;
    else                         c = COL_OTHER;
    return c;
  endfunction

  // corner visited by vertex k of the 24-vertex line list (vertex pairs form the box edges)
  function automatic logic [2:0] corner_of(input logic [4:0] k);
    logic [2:0] c;
    case (k)
      5'd0:  c = 3'd0;  5'd1:  c = 3'd1;
      5'd2:  c = 3'd0;  5'd3:  c = 3'd2;
      5'd4:  c = 3'd0;  5'd5:  c = 3'd4;
      5'd6:  c = 3'd3;  5'd7:  c = 3'd1;
      5'd8:  c = 3'd3;  5'd9:  c = 3'd2;
      5'd10: c = 3'd3;  5'd11: c = 3'd7;
      5'd12: c = 3'd5;  5'd13: c = 3'd1;
      5'd14: c = 3'd5;  5'd15: c = 3'd4;
      5'd16: c = 3'd5;  5'd17: c = 3'd7;
      5'd18: c = 3'd6;  5'd19: c = 3'd2;
      5'd20: c = 3'd6;  5'd21: c = 3'd4;
      5'd22: c = 3'd6;  5'd23: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

### hdl/obwg_front.sv
// ----------------------------------------------------------------------------
// obwg_front
// Accepts items, handles frame starts and the capacity check, queues boxes.
// ----------------------------------------------------------------------------
module obwg_front import obwg_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic [CAP_W-1:0]     capacity,
  input  logic                 full,
  output logic                 push,
  output box_t                 push_box
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] need, cap_eff;
  logic             accept, fits;

  assign s_tready = !full;
  assign accept   = s_tvalid && !full;
  assign need     = CMP_W'(count) + CMP_W'(BOX_VERTS);
  assign cap_eff  = (CMP_W'(capacity) < CMP_W'(MAX_VERTICES)) ?
                    CMP_W'(capacity) : CMP_W'(MAX_VERTICES);
  assign fits     = need <= cap_eff;
  assign push     = accept && !s_tuser && fits;

  always_comb begin
    push_box.cx    = s_tdata[31:0];
    push_box.cy    = s_tdata[63:32];
    push_box.cz    = s_tdata[95:64];
    push_box.qw    = s_tdata[111:96];
    push_box.qx    = s_tdata[127:112];
    push_box.qy    = s_tdata[143:128];
    push_box.qz    = s_tdata[159:144];
    push_box.sx    = s_tdata[190:160];
    push_box.sy    = s_tdata[221:191];
    push_box.sz    = s_tdata[252:222];
    push_box.color = pick_color(s_tdata[260:253]);
    push_box.base  = 12'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_tuser) begin
      count <= '0;
    end else if (push) begin
      count <= CNT_W'(need);
    end
  end

endmodule

### hdl/obwg_fifo.sv
// ----------------------------------------------------------------------------
// obwg_fifo
// Short box queue between the front and the back.
// ----------------------------------------------------------------------------
module obwg_fifo import obwg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  box_t push_box,
  output logic full,
  input  logic pop,
  output box_t pop_box,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  box_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;

  assign full    = level == LVL_W'(DEPTH);
  assign empty   = level == '0;
  assign pop_box = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

### hdl/obwg_back.sv
// ----------------------------------------------------------------------------
// obwg_back
// Rotation matrix, corner build and vertex emission for one box at a time.
// ----------------------------------------------------------------------------
module obwg_back import obwg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  box_t                  pop_box,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [3:0]            m_tuser,
  output logic                  m_tlast
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQ   = 7'b0000010,
    ST_NUM  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  localparam logic signed [31:0] M_ONE = 32'sh4000_0000;

  state_t             state;
  box_t               bx;
  logic [4:0]         cnt;
  logic signed [31:0] pr [10];
  logic signed [33:0] num [9];
  logic [32:0]        n;
  logic signed [31:0] m [9];
  logic signed [63:0] p [9];
  logic signed [31:0] cr_x [8];
  logic signed [31:0] cr_y [8];
  logic signed [31:0] cr_z [8];
  logic signed [63:0] acc;
  logic [2:0]         kk;
  logic [1:0]         ii;
  logic               sub;
  // divider
  logic               div_busy;
  logic [4:0]         bitcnt;
  logic [32:0]        rem;
  logic [30:0]        dvd;
  logic [30:0]        quo;
  logic               neg;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [33:0] e_ww, e_xx, e_yy, e_zz, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
  logic [32:0]        n_c;
  logic signed [33:0] num_sel;
  logic [32:0]        mag;
  logic [62:0]        dividend;
  logic [33:0]        rt;
  logic               qbit;
  logic [30:0]        quo_next;
  logic signed [63:0] p0, p1, p2, acc_next, t_round;
  logic signed [32:0] sh;
  logic signed [31:0] ctr;
  logic signed [33:0] csum;
  logic signed [31:0] csat;
  logic [2:0]         ci;
  logic               load_out;

  assign mul_p = mul_a * mul_b;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_MUL) begin
      mul_a = m[cnt[3:0] < 4'd9 ? cnt[3:0] : 4'd0];
      case (cnt)
        5'd0, 5'd3, 5'd6: mul_b = $signed({1'b0, bx.sx});
        5'd1, 5'd4, 5'd7: mul_b = $signed({1'b0, bx.sy});
        default:          mul_b = $signed({1'b0, bx.sz});
      endcase
    end else begin
      case (cnt)
        5'd0:    begin mul_a = 32'(bx.qw); mul_b = 32'(bx.qw); end
        5'd1:    begin mul_a = 32'(bx.qx); mul_b = 32'(bx.qx); end
        5'd2:    begin mul_a = 32'(bx.qy); mul_b = 32'(bx.qy); end
        5'd3:    begin mul_a = 32'(bx.qz); mul_b = 32'(bx.qz); end
        5'd4:    begin mul_a = 32'(bx.qx); mul_b = 32'(bx.qy); end
        5'd5:    begin mul_a = 32'(bx.qw); mul_b = 32'(bx.qz); end
        5'd6:    begin mul_a = 32'(bx.qx); mul_b = 32'(bx.qz); end
        5'd7:    begin mul_a = 32'(bx.qw); mul_b = 32'(bx.qy); end
        5'd8:    begin mul_a = 32'(bx.qy); mul_b = 32'(bx.qz); end
        5'd9:    begin mul_a = 32'(bx.qw); mul_b = 32'(bx.qx); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // products as 34-bit signed terms
  assign e_ww = 34'(pr[0]);
  assign e_xx = 34'(pr[1]);
  assign e_yy = 34'(pr[2]);
  assign e_zz = 34'(pr[3]);
  assign e_xy = 34'(pr[4]);
  assign e_wz = 34'(pr[5]);
  assign e_xz = 34'(pr[6]);
  assign e_wy = 34'(pr[7]);
  assign e_yz = 34'(pr[8]);
  assign e_wx = 34'(pr[9]);
  assign n_c  = 33'(e_ww + e_xx + e_yy + e_zz);

  // restoring divider, one quotient bit per cycle
  assign num_sel  = num[cnt[3:0] < 4'd9 ? cnt[3:0] : 4'd0];
  assign mag      = num_sel[33] ? 33'(-num_sel) : 33'(num_sel);
  assign dividend = {mag[32:0], 30'd0} + 63'(n[32:1]);
  assign rt       = {rem, dvd[30]};
  assign qbit     = rt >= {1'b0, n};
  assign quo_next = {quo[29:0], qbit};

  // corner component: signed sum of the three scaled axes, rounded, added to the center and saturated
  always_comb begin
    case (ii)
      2'd0:    begin p0 = p[0]; p1 = p[1]; p2 = p[2]; ctr = bx.cx; end
      2'd1:    begin p0 = p[3]; p1 = p[4]; p2 = p[5]; ctr = bx.cy; end
      default: begin p0 = p[6]; p1 = p[7]; p2 = p[8]; ctr = bx.cz; end
    endcase
    acc_next = (kk[2] ? p0 : -p0) + (kk[1] ? p1 : -p1) + (kk[0] ? p2 : -p2);
    // round half up, then shift
    t_round  = acc + 64'sh4000_0000;
    sh       = 33'(t_round >>> 31);
    csum     = 34'(ctr) + 34'(sh);
    if (csum > 34'sh0_7FFF_FFFF) begin
      csat = 32'sh7FFF_FFFF;
    end else if (csum < -34'sh0_8000_0000) begin
      csat = 32'sh8000_0000;
    end else begin
      csat = 32'(csum);
    end
  end

  assign pop      = (state == ST_IDLE) && !empty;
  assign ci       = corner_of(cnt);
  assign load_out = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      div_busy <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= ST_SQ;
            cnt   <= '0;
          end
        end
        ST_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd9) begin
            state <= ST_NUM;
          end
        end
        ST_NUM: begin
          cnt <= '0;
          state <= (n_c <= 33'(LEN_SQ_EPS)) ? ST_MUL : ST_DIV;
        end
        ST_DIV: begin
          if (!div_busy) begin
            div_busy <= 1'b1;
          end else if (bitcnt == 5'd30) begin
            div_busy <= 1'b0;
            if (cnt == 5'd8) begin
              cnt   <= '0;
              state <= ST_MUL;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd8) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (sub && ii == 2'd2 && kk == 3'd7) begin
            state <= ST_EMIT;
            cnt   <= '0;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            cnt <= cnt + 1'b1;
            if (cnt == 5'(BOX_VERTS - 1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bx  <= pop_box;
        kk  <= '0;
        ii  <= '0;
        sub <= 1'b0;
      end
      ST_SQ: begin
        if (cnt < 5'd10) begin
          pr[cnt[3:0]] <= 32'(mul_p);
        end
      end
      ST_NUM: begin
        n      <= n_c;
        num[0] <= e_ww + e_xx - e_yy - e_zz;
        num[1] <= (e_xy - e_wz) <<< 1;
        num[2] <= (e_xz + e_wy) <<< 1;
        num[3] <= (e_xy + e_wz) <<< 1;
        num[4] <= e_ww - e_xx + e_yy - e_zz;
        num[5] <= (e_yz - e_wx) <<< 1;
        num[6] <= (e_xz - e_wy) <<< 1;
        num[7] <= (e_yz + e_wx) <<< 1;
        num[8] <= e_ww - e_xx - e_yy + e_zz;
        for (int r = 0; r < 9; r++) begin
          m[r] <= (r == 0 || r == 4 || r == 8) ? M_ONE : '0;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          rem    <= {1'b0, dividend[62:31]};
          dvd    <= dividend[30:0];
          quo    <= '0;
          neg    <= num_sel[33];
          bitcnt <= '0;
        end else begin
          rem    <= qbit ? 33'(rt - {1'b0, n}) : rt[32:0];
          dvd    <= {dvd[29:0], 1'b0};
          quo    <= quo_next;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 5'd30) begin
            m[cnt[3:0]] <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
          end
        end
      end
      ST_MUL: begin
        if (cnt < 5'd9) begin
          p[cnt[3:0]] <= mul_p;
        end
      end
      ST_ACC: begin
        sub <= !sub;
        if (!sub) begin
          acc <= acc_next;
        end else begin
          case (ii)
            2'd0:    cr_x[kk] <= csat;
            2'd1:    cr_y[kk] <= csat;
            default: cr_z[kk] <= csat;
          endcase
          if (ii == 2'd2) begin
            ii <= '0;
            kk <= kk + 1'b1;
          end else begin
            ii <= ii + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {4'd0, bx.base + 12'(cnt), cr_z[ci], cr_y[ci], cr_x[ci]};
      m_tuser <= bx.color;
      m_tlast <= cnt == 5'(BOX_VERTS - 1);
    end
  end

endmodule

### hdl/oriented_box_wireframe_generator.sv
// ----------------------------------------------------------------------------
// oriented_box_wireframe_generator
// Turns oriented boxes into 24 line-list vertices each.
// ----------------------------------------------------------------------------
// A box item is checked against the frame's vertex capacity on entry and
// queued if it fits; a frame-start item clears the count. The back end then
// takes one box at a time: it takes the box, forms ten quaternion products
// on a shared 32x32 multiplier, checks the length, computes 9 matrix
// entries through a bit-serial divider (skipped for a near-zero
// quaternion), scales the axes, builds the corner sums and outputs 24
// vertices, and the output can stall on m_tready. The two-entry queue
// lets the input keep taking items while a box is being worked on.
module oriented_box_wireframe_generator import obwg_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // box items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // center_x, center_y, center_z, quat_w, quat_x, quat_y, quat_z,
  // size_x, size_y, size_z, class_bits, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,   // op
  // vertices
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pos_x, pos_y, pos_z, vertex_slot, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [3:0]            m_tuser,   // color_code
  output logic                  m_tlast
);

  logic [CAP_W-1:0] capacity;
  logic             push, full, pop, empty;
  box_t             push_box, pop_box;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  obwg_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .capacity (capacity),
    .full     (full),
    .push     (push),
    .push_box (push_box)
  );

  obwg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_box (push_box),
    .full     (full),
    .pop      (pop),
    .pop_box  (pop_box),
    .empty    (empty)
  );

  obwg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_box  (pop_box),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
